// File: rtl/nearest_neighbor_tour_unit_defines.svh
// Assertion macros for the nearest-neighbour tour unit.
// Included by the modules that carry concurrent checks; needs nothing else.
`ifndef NEAREST_NEIGHBOR_TOUR_UNIT_DEFINES_SVH
`define NEAREST_NEIGHBOR_TOUR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define NNT_CHECK(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define NNT_CHECK_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/nnt_pkg.sv
// Shared types and constants for the nearest-neighbour tour unit.
// No dependencies; used by the front end, the queue, the back end and the top level.
package nnt_pkg;

   // Width of the point index on the result channel
   localparam int PIDX_BITS = 5;

   // Classification of one input transaction by the front end
   typedef struct packed {
      logic keep;       // point fits in the store
      logic final_pt;   // last point of the set, starts the tour
   } nnt_flags_type;

   // Queue occupancy seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } nnt_q_status_type;

   // Back-end sequencer states
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_DRAIN = 5'b00100,
      ST_EMIT  = 5'b01000,
      ST_CLOSE = 5'b10000
   } nnt_state_type;

endpackage

// File: rtl/nearest_neighbor_tour_unit.sv
// Nearest-neighbour tour unit. Points are loaded one per transaction through a
// two-entry queue; the transaction flagged final starts the tour.
// A tour of n points makes n scans, each reading the n stored coordinates from a
// single-read-port memory one per cycle, followed by a drain of the distance
// pipeline and the hand-over of the result; a tour returns n+1 results: the visited
// indices starting at point 0, then a closing point 0 with tour_end set.
// Points beyond POINTS are discarded and dropped_points is set on every result of
// that tour. No clearing pass is needed after reset.
module nearest_neighbor_tour_unit #(
   parameter int POINTS     = 32,
   parameter int COORD_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [COORD_BITS-1:0]   req_coord_x,
   input  logic signed [COORD_BITS-1:0]   req_coord_y,
   input  logic                           req_final_point,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [nnt_pkg::PIDX_BITS-1:0]  rsp_point_index,
   output logic                           rsp_tour_end,
   output logic                           rsp_dropped_points
);
   import nnt_pkg::*;

   localparam int IDX_BITS = (POINTS > 1) ? $clog2(POINTS) : 1;
   localparam int CNT_BITS = $clog2(POINTS + 1);
   localparam int QW       = 2 * COORD_BITS + IDX_BITS + CNT_BITS + 2;

   nnt_q_status_type q_status;
   logic             q_push, q_pop;
   logic [QW-1:0]    q_wdata, q_rdata;

   nnt_front #(
      .POINTS     (POINTS),
      .COORD_BITS (COORD_BITS),
      .IDX_BITS   (IDX_BITS),
      .CNT_BITS   (CNT_BITS),
      .QW         (QW)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .coord_x     (req_coord_x),
      .coord_y     (req_coord_y),
      .final_point (req_final_point),
      .q_status    (q_status),
      .q_push      (q_push),
      .q_data      (q_wdata)
   );

   nnt_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .status    (q_status)
   );

   nnt_back #(
      .POINTS     (POINTS),
      .COORD_BITS (COORD_BITS),
      .IDX_BITS   (IDX_BITS),
      .CNT_BITS   (CNT_BITS),
      .QW         (QW)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_status           (q_status),
      .q_data             (q_rdata),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_point_index    (rsp_point_index),
      .rsp_tour_end       (rsp_tour_end),
      .rsp_dropped_points (rsp_dropped_points)
   );

endmodule

// File: rtl/nnt_queue.sv
// Two-entry queue between the front end and the back end of the tour unit.
// Depends on nnt_pkg for the occupancy struct.
module nnt_queue #(
   parameter int WIDTH = 40
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [WIDTH-1:0]          push_data,
   input  logic                      pop,
   output logic [WIDTH-1:0]          pop_data,
   output nnt_pkg::nnt_q_status_type status
);
   import nnt_pkg::*;

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;

   assign status.full  = (fill_ff == 2'd2);
   assign status.empty = (fill_ff == 2'd0);
   assign pop_data     = slot_ff[rd_ptr_ff];

   // pointer and fill update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = 2'(fill_ff + 2'd1);
      end else if (pop && !push) begin
         fill_in = 2'(fill_ff - 2'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // payload slots, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/nnt_front.sv
// Front end of the tour unit: takes point transactions, assigns store slots,
// flags overflow and marks the set end. Depends on nnt_pkg.
module nnt_front #(
   parameter int POINTS     = 32,
   parameter int COORD_BITS = 16,
   parameter int IDX_BITS   = 5,
   parameter int CNT_BITS   = 6,
   parameter int QW         = 45
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [COORD_BITS-1:0]     coord_x,
   input  logic [COORD_BITS-1:0]     coord_y,
   input  logic                      final_point,
   input  nnt_pkg::nnt_q_status_type q_status,
   output logic                      q_push,
   output logic [QW-1:0]             q_data
);
   import nnt_pkg::*;

   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [CNT_BITS-1:0] cnt_after;
   nnt_flags_type       flags;

   // classify the incoming point
   assign flags.keep     = (cnt_ff != CNT_BITS'(POINTS));
   assign flags.final_pt = final_point;
   assign cnt_after      = flags.keep ? CNT_BITS'(cnt_ff + 1'b1) : cnt_ff;

   assign req_stall = q_status.full;
   assign q_push    = req_valid && !q_status.full;
   assign q_data    = {coord_x, coord_y, cnt_ff[IDX_BITS-1:0], cnt_after, flags};

   // points held in the current set; restarts after the final point
   always_comb begin
      cnt_in = cnt_ff;
      if (q_push) begin
         cnt_in = flags.final_pt ? '0 : cnt_after;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

// File: rtl/nnt_back.sv
// Back end of the tour unit: coordinate memory, distance pipeline, greedy
// selection and result register. Depends on nnt_pkg and the assertion macros.
`include "nearest_neighbor_tour_unit_defines.svh"

module nnt_back #(
   parameter int POINTS     = 32,
   parameter int COORD_BITS = 16,
   parameter int IDX_BITS   = 5,
   parameter int CNT_BITS   = 6,
   parameter int QW         = 45
) (
   input  logic                         clock,
   input  logic                         reset,
   input  nnt_pkg::nnt_q_status_type    q_status,
   input  logic [QW-1:0]                q_data,
   output logic                         q_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [nnt_pkg::PIDX_BITS-1:0] rsp_point_index,
   output logic                         rsp_tour_end,
   output logic                         rsp_dropped_points
);
   import nnt_pkg::*;

   localparam int CB        = COORD_BITS;
   localparam int SQ_BITS   = 2 * (CB + 1);
   localparam int DIST_BITS = SQ_BITS + 1;
   localparam int CNT_LO    = 2;
   localparam int SLOT_LO   = CNT_LO + CNT_BITS;
   localparam int Y_LO      = SLOT_LO + IDX_BITS;
   localparam int X_LO      = Y_LO + CB;

   // absolute difference of two signed coordinates
   function automatic logic [CB:0] abs_diff(input logic [CB-1:0] a, input logic [CB-1:0] b);
      logic [CB:0] diff;
      diff = {a[CB-1], a} - {b[CB-1], b};
      return diff[CB] ? (~diff + 1'b1) : diff;
   endfunction

   // queue entry fields
   nnt_flags_type       q_flags;
   logic [CNT_BITS-1:0] q_cnt;
   logic [IDX_BITS-1:0] q_slot;
   logic [CB-1:0]       q_x, q_y;

   assign q_flags = q_data[1:0];
   assign q_cnt   = q_data[SLOT_LO-1:CNT_LO];
   assign q_slot  = q_data[Y_LO-1:SLOT_LO];
   assign q_y     = q_data[X_LO-1:Y_LO];
   assign q_x     = q_data[X_LO+CB-1:X_LO];

   // sequencer state
   nnt_state_type       state_ff, state_in;
   logic [IDX_BITS-1:0] j_ff, j_in;
   logic [CNT_BITS-1:0] step_ff, step_in;
   logic [CNT_BITS-1:0] n_ff, n_in;
   logic                first_ff, first_in;
   logic                ovf_ff, ovf_in;
   logic [POINTS-1:0]   vis_ff, vis_in;
   logic                found_ff, found_in;
   logic [DIST_BITS-1:0] best_d_ff, best_d_in;
   logic [IDX_BITS-1:0] best_idx_ff, best_idx_in;
   logic [CB-1:0]       best_x_ff, best_x_in, best_y_ff, best_y_in;
   logic [CB-1:0]       cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic                in_tour;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [PIDX_BITS-1:0] rsp_idx_ff, rsp_idx_in;
   logic                 rsp_end_ff, rsp_end_in;
   logic                 rsp_drop_ff, rsp_drop_in;
   logic                 out_free;
   logic                 load_rsp;
   logic [31:0]          best_wide;

   // memory and distance pipeline
   logic [2*CB-1:0]      mem [POINTS];
   logic [2*CB-1:0]      rd_ff;
   logic                 issue, cand;
   logic                 s1_vld_ff, s2_vld_ff, s3_vld_ff;
   logic [IDX_BITS-1:0]  s1_idx_ff, s2_idx_ff, s3_idx_ff;
   logic [CB-1:0]        s2_x_ff, s2_y_ff, s3_x_ff, s3_y_ff;
   logic [CB:0]          s2_ax_ff, s2_ay_ff;
   logic [SQ_BITS-1:0]   s3_sqx_ff, s3_sqy_ff;
   logic [DIST_BITS-1:0] sq_dist;
   logic                 better;

   assign q_pop    = (state_ff == ST_IDLE) && !q_status.empty;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign issue    = (state_ff == ST_SCAN);
   assign cand     = first_ff ? (j_ff == '0) : !vis_ff[j_ff];
   assign sq_dist  = DIST_BITS'(s3_sqx_ff) + DIST_BITS'(s3_sqy_ff);
   assign better   = s3_vld_ff && (!found_ff || (sq_dist < best_d_ff));
   assign best_wide = 32'(best_idx_ff);
   assign in_tour  = (state_ff == ST_SCAN) || (state_ff == ST_DRAIN) || (state_ff == ST_EMIT);

   // coordinate memory: one write port for loading, one registered read for the scan
   always_ff @(posedge clock) begin
      if (q_pop && q_flags.keep) begin
         mem[q_slot] <= {q_x, q_y};
      end
      rd_ff <= mem[j_ff];
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= issue && cand;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   // differences, then squares
   always_ff @(posedge clock) begin
      s1_idx_ff <= j_ff;
      s2_idx_ff <= s1_idx_ff;
      s2_x_ff   <= rd_ff[2*CB-1:CB];
      s2_y_ff   <= rd_ff[CB-1:0];
      s2_ax_ff  <= abs_diff(rd_ff[2*CB-1:CB], cur_x_ff);
      s2_ay_ff  <= abs_diff(rd_ff[CB-1:0], cur_y_ff);
      s3_idx_ff <= s2_idx_ff;
      s3_x_ff   <= s2_x_ff;
      s3_y_ff   <= s2_y_ff;
      s3_sqx_ff <= s2_ax_ff * s2_ax_ff;
      s3_sqy_ff <= s2_ay_ff * s2_ay_ff;
   end

   // sequencer, best tracking and result loading
   always_comb begin
      state_in     = state_ff;
      j_in         = j_ff;
      step_in      = step_ff;
      n_in         = n_ff;
      first_in     = first_ff;
      ovf_in       = ovf_ff;
      vis_in       = vis_ff;
      found_in     = found_ff;
      best_d_in    = best_d_ff;
      best_idx_in  = best_idx_ff;
      best_x_in    = best_x_ff;
      best_y_in    = best_y_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_idx_in   = rsp_idx_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_drop_in  = rsp_drop_ff;
      load_rsp     = 1'b0;

      // nearest so far, lowest index on ties by scan order
      if (better) begin
         found_in    = 1'b1;
         best_d_in   = sq_dist;
         best_idx_in = s3_idx_ff;
         best_x_in   = s3_x_ff;
         best_y_in   = s3_y_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               ovf_in = ovf_ff || !q_flags.keep;
               if (q_flags.final_pt) begin
                  n_in     = q_cnt;
                  step_in  = '0;
                  j_in     = '0;
                  first_in = 1'b1;
                  found_in = 1'b0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            j_in = IDX_BITS'(j_ff + 1'b1);
            if (CNT_BITS'(j_ff) == CNT_BITS'(n_ff - 1'b1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!s1_vld_ff && !s2_vld_ff && !s3_vld_ff) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               load_rsp              = 1'b1;
               rsp_valid_in          = 1'b1;
               rsp_idx_in            = best_wide[PIDX_BITS-1:0];
               rsp_end_in            = 1'b0;
               rsp_drop_in           = ovf_ff;
               vis_in[best_idx_ff]   = 1'b1;
               cur_x_in              = best_x_ff;
               cur_y_in              = best_y_ff;
               step_in               = CNT_BITS'(step_ff + 1'b1);
               j_in                  = '0;
               first_in              = 1'b0;
               found_in              = 1'b0;
               state_in = (CNT_BITS'(step_ff + 1'b1) == n_ff) ? ST_CLOSE : ST_SCAN;
            end
         end
         ST_CLOSE: begin
            if (out_free) begin
               load_rsp     = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_idx_in   = '0;
               rsp_end_in   = 1'b1;
               rsp_drop_in  = ovf_ff;
               vis_in       = '0;
               ovf_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         j_ff         <= '0;
         step_ff      <= '0;
         n_ff         <= '0;
         first_ff     <= 1'b0;
         ovf_ff       <= 1'b0;
         vis_ff       <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         j_ff         <= j_in;
         step_ff      <= step_in;
         n_ff         <= n_in;
         first_ff     <= first_in;
         ovf_ff       <= ovf_in;
         vis_ff       <= vis_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      best_d_ff   <= best_d_in;
      best_idx_ff <= best_idx_in;
      best_x_ff   <= best_x_in;
      best_y_ff   <= best_y_in;
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      if (load_rsp) begin
         rsp_idx_ff  <= rsp_idx_in;
         rsp_end_ff  <= rsp_end_in;
         rsp_drop_ff <= rsp_drop_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_point_index    = rsp_idx_ff;
   assign rsp_tour_end       = rsp_end_ff;
   assign rsp_dropped_points = rsp_drop_ff;

   // a finished scan always has a candidate
   `NNT_CHECK(a_emit_found, clock, reset, state_ff == ST_EMIT, found_ff, "emit without candidate")
   // the chosen point was not visited before
   `NNT_CHECK(a_emit_fresh, clock, reset, state_ff == ST_EMIT, !vis_ff[best_idx_ff], "revisited point")
   // step count stays below the set size in the scan, drain and emit states
   `NNT_CHECK(a_step_range, clock, reset, in_tour, step_ff < n_ff, "step overrun")
   // closing transaction leaves the marks cleared for the next set
   `NNT_CHECK_NEXT(a_close_clear, clock, reset, state_ff == ST_CLOSE && out_free, vis_ff == '0, "marks not cleared")

endmodule
